// File: sv/flf_pkg.sv
// Package for the first-fit free list: sizes, request codes and shared types.
package flf_pkg;

    localparam int CAPACITY   = 64;
    localparam int ADDR_BITS  = 48;
    localparam int SIZE_BITS  = 32;
    localparam int TOTAL_BITS = 40;
    localparam int REQ_BITS   = 3;

    localparam int CNT_BITS      = $clog2(CAPACITY + 1);
    localparam int IN_DATA_BITS  = ((ADDR_BITS + SIZE_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_BITS = ((ADDR_BITS + SIZE_BITS + TOTAL_BITS + 7) / 8) * 8;
    localparam int OUT_USER_BITS = 2;

    localparam logic [REQ_BITS-1:0] REQ_FREE         = 3'd0;
    localparam logic [REQ_BITS-1:0] REQ_OBTAIN_SMALL = 3'd1;
    localparam logic [REQ_BITS-1:0] REQ_OBTAIN_LARGE = 3'd2;
    localparam logic [REQ_BITS-1:0] REQ_LOOKUP_SMALL = 3'd3;
    localparam logic [REQ_BITS-1:0] REQ_LOOKUP_LARGE = 3'd4;
    localparam logic [REQ_BITS-1:0] REQ_CLEAR        = 3'd5;

    typedef struct packed {
        logic [ADDR_BITS-1:0] addr;
        logic [SIZE_BITS-1:0] size;
    } slot_t;

    typedef struct packed {
        logic push;
        logic pull;
        logic sel;
        logic live;
    } cell_ctrl_t;

endpackage

// File: sv/flf_cell.sv
// One slot of the free list: holds a block, tests its fit, shifts toward either neighbor.
module flf_cell (
    input  logic                           clk,
    input  flf_pkg::cell_ctrl_t            ctrl,
    input  logic [flf_pkg::SIZE_BITS-1:0]  want,
    input  flf_pkg::slot_t                 left_q,
    input  flf_pkg::slot_t                 right_q,
    output flf_pkg::slot_t                 q,
    output logic                           fit,
    output flf_pkg::slot_t                 pick
);
    import flf_pkg::*;

    slot_t slot_reg;
    slot_t slot_next;

    always_comb
    begin
        slot_next = slot_reg;
        if (ctrl.push)
        begin
            slot_next = left_q;
        end
        else if (ctrl.pull)
        begin
            slot_next = right_q;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
    end

    assign q    = slot_reg;
    assign fit  = ctrl.live && (slot_reg.size >= want);
    assign pick = ctrl.sel ? slot_reg : '0;

endmodule

// File: sv/free_list_first_fit.sv
// Top level of the first-fit free list: request control, cell row and result register.
//
//  channel  dir  handshake        tdata (low bit up)                    tuser (low bit up)
//  s_axis   in   tvalid/tready    block_addr[47:0] size_value[79:48]    req_type[2:0]
//  m_axis   out  tvalid/tready    out_addr[47:0] out_size[79:48]        found[0] store_full[1]
//                                 total_free[119:80]
//
//  Each request passes two states: the accept edge registers each cell's size compare,
//  then the execute state resolves the first fit and updates the cell row and the result.
//  The update waits in the execute state while the result register is still held.
//  A new request is taken while a result waits to be transferred.
//  rst_n clears count, total and handshake state; slot contents are not reset.
module free_list_first_fit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [flf_pkg::IN_DATA_BITS-1:0]   s_axis_tdata,   // block_addr, size_value
    input  logic [flf_pkg::REQ_BITS-1:0]       s_axis_tuser,   // req_type
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [flf_pkg::OUT_DATA_BITS-1:0]  m_axis_tdata,   // out_addr, out_size, total_free
    output logic [flf_pkg::OUT_USER_BITS-1:0]  m_axis_tuser    // found, store_full
);
    import flf_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic                     state_reg, state_next;
    logic [CNT_BITS-1:0]      count_reg, count_next;
    logic [TOTAL_BITS-1:0]    total_reg, total_next;
    logic [REQ_BITS-1:0]      req_reg;
    logic [ADDR_BITS-1:0]     addr_reg;
    logic [SIZE_BITS-1:0]     size_reg;
    logic [CAPACITY-1:0]      fit_reg;
    logic                     gate_reg;
    logic                     out_valid_reg, out_valid_next;
    logic [OUT_DATA_BITS-1:0] out_data_reg;
    logic [OUT_USER_BITS-1:0] out_user_reg;

    logic [ADDR_BITS-1:0]     in_addr;
    logic [SIZE_BITS-1:0]     in_size;
    logic                     accept;
    logic                     commit;
    logic [CAPACITY-1:0]      fit_now;
    logic [CAPACITY-1:0]      fit_use;
    logic [CAPACITY-1:0]      first_hit;
    logic [CAPACITY-1:0]      from_hit;
    logic                     found;
    logic                     is_obtain;
    logic                     full;
    logic                     push_all;
    logic                     pull_all;
    slot_t                    new_slot;
    slot_t                    hit_slot;
    slot_t                    cell_q    [CAPACITY];
    slot_t                    cell_pick [CAPACITY];
    cell_ctrl_t               cell_ctrl [CAPACITY];

    assign in_addr  = s_axis_tdata[ADDR_BITS-1:0];
    assign in_size  = s_axis_tdata[ADDR_BITS +: SIZE_BITS];
    assign accept   = s_axis_tvalid && s_axis_tready;
    assign commit   = (state_reg == ST_EXEC) && (!out_valid_reg || m_axis_tready);
    assign new_slot = '{addr: addr_reg, size: size_reg};

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            slot_t left_q;
            slot_t right_q;

            if (gi == 0)
            begin : g_head
                assign left_q = new_slot;
            end
            else
            begin : g_body
                assign left_q = cell_q[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_tail
                assign right_q = cell_q[gi];
            end
            else
            begin : g_mid
                assign right_q = cell_q[gi+1];
            end

            assign cell_ctrl[gi] = '{push: push_all,
                                     pull: pull_all && from_hit[gi],
                                     sel:  first_hit[gi],
                                     live: CNT_BITS'(gi) < count_reg};

            flf_cell u_cell (
                .clk     (clk),
                .ctrl    (cell_ctrl[gi]),
                .want    (in_size),
                .left_q  (left_q),
                .right_q (right_q),
                .q       (cell_q[gi]),
                .fit     (fit_now[gi]),
                .pick    (cell_pick[gi])
            );
        end
    endgenerate

    always_comb
    begin
        fit_use   = '0;
        is_obtain = 1'b0;
        case (req_reg)
            REQ_OBTAIN_SMALL:
            begin
                fit_use   = fit_reg & CAPACITY'(1);
                is_obtain = 1'b1;
            end
            REQ_OBTAIN_LARGE:
            begin
                fit_use   = fit_reg;
                is_obtain = 1'b1;
            end
            REQ_LOOKUP_SMALL:
            begin
                fit_use = fit_reg & CAPACITY'(1);
            end
            REQ_LOOKUP_LARGE:
            begin
                fit_use = gate_reg ? '0 : fit_reg;
            end
            default:
            begin
                fit_use = '0;
            end
        endcase
    end

    assign first_hit = fit_use & (~fit_use + CAPACITY'(1));
    assign from_hit  = ~(first_hit - CAPACITY'(1));
    assign found     = |fit_use;
    assign full      = (req_reg == REQ_FREE) && (count_reg == CNT_BITS'(CAPACITY));
    assign push_all  = commit && (req_reg == REQ_FREE) && !full;
    assign pull_all  = commit && found && is_obtain;

    always_comb
    begin
        hit_slot = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            hit_slot = hit_slot | cell_pick[i];
        end
    end

    always_comb
    begin
        count_next = count_reg;
        total_next = total_reg;
        if (push_all)
        begin
            count_next = count_reg + CNT_BITS'(1);
            total_next = total_reg + TOTAL_BITS'(size_reg);
        end
        else if (pull_all)
        begin
            count_next = count_reg - CNT_BITS'(1);
            total_next = total_reg - TOTAL_BITS'(hit_slot.size);
        end
        else if (commit && (req_reg == REQ_CLEAR))
        begin
            count_next = '0;
            total_next = '0;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (commit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg  <= s_axis_tuser;
            addr_reg <= in_addr;
            size_reg <= in_size;
            fit_reg  <= fit_now;
            gate_reg <= total_reg < TOTAL_BITS'(in_size);
        end
        if (commit)
        begin
            out_data_reg <= OUT_DATA_BITS'({total_next,
                                            found ? hit_slot.size : SIZE_BITS'(0),
                                            found ? hit_slot.addr : ADDR_BITS'(0)});
            out_user_reg <= {full, found};
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_BITS'(CAPACITY))
        else $error("slot count above capacity");

    a_result_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(state_reg) == ST_EXEC)
        else $error("result appeared without an executed request");

    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        push_all |=> count_reg == $past(count_reg) + CNT_BITS'(1))
        else $error("free did not grow the list by one");

    a_pull_count: assert property (@(posedge clk) disable iff (!rst_n)
        pull_all |=> count_reg == $past(count_reg) - CNT_BITS'(1))
        else $error("obtain did not shrink the list by one");

    a_full_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[1]) |-> count_reg == CNT_BITS'(CAPACITY))
        else $error("store_full reported with room left");

endmodule
